// File: hw/rtl/binary_erode_dilate_window_macros.svh
// Assertion macros for the binary erode/dilate window block.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef BINARY_ERODE_DILATE_WINDOW_MACROS_SVH
`define BINARY_ERODE_DILATE_WINDOW_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BEDW_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define BEDW_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BEDW_CHECK(label, cond, msg)

`define BEDW_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bedw_pkg.sv
// Shared constants, types and helper functions for the binary erode/dilate window.
// No dependencies.
package bedw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WIN    = 15;
  localparam int MAX_HEIGHT = 1024;

  localparam int HALF_WIN = (MAX_WIN - 1) / 2;
  localparam int HW_W     = $clog2(HALF_WIN + 1);
  localparam int SPAN_W   = HW_W + 1;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int INROW_W  = $clog2(MAX_HEIGHT + MAX_WIN + 1);
  localparam int WDIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W   = $clog2(MAX_HEIGHT + 1);
  localparam int LAG_W    = $clog2(HALF_WIN * MAX_WIDTH + HALF_WIN + 1);
  localparam int STORE_W  = MAX_WIN - 1;

  localparam int WSIZE_W     = 4;
  localparam int DIM_FIELD_W = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 3'd4;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam int RST_WIN   = 3;
  localparam int RST_IMG_W = 640;
  localparam int RST_IMG_H = 480;

  typedef logic [MAX_WIN-1:0] column_t;

  typedef struct packed {
    column_t row_win;
    column_t row_sel;
    column_t col_win;
    column_t col_sel;
    logic    all_ok;
  } win_mask_t;

  // half of the odd window size: even sizes round down, zero acts as one
  function automatic logic [HW_W-1:0] half_size(input logic [WSIZE_W-1:0] size);
    logic [WSIZE_W-1:0] half;
    half = (size == '0) ? '0 : ((size - 1'b1) >> 1);
    if (int'(half) > HALF_WIN) half = WSIZE_W'(HALF_WIN);
    return half[HW_W-1:0];
  endfunction

  function automatic logic [WDIM_W-1:0] eff_width(input logic [DIM_FIELD_W-1:0] v);
    if (v == '0) return WDIM_W'(1);
    if (int'(v) > MAX_WIDTH) return WDIM_W'(MAX_WIDTH);
    return WDIM_W'(v);
  endfunction

  function automatic logic [HDIM_W-1:0] eff_height(input logic [DIM_FIELD_W-1:0] v);
    if (v == '0) return HDIM_W'(1);
    if (int'(v) > MAX_HEIGHT) return HDIM_W'(MAX_HEIGHT);
    return HDIM_W'(v);
  endfunction

endpackage

// File: hw/rtl/bedw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bedw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/bedw_window.sv
// Window column registers and the erode/dilate reduction over them.
// Depends on bedw_pkg.
module bedw_window (
  input  logic                clk,
  input  logic                shift_en,
  input  bedw_pkg::column_t   col_in,
  input  bedw_pkg::win_mask_t mask_in,
  input  logic                mode,
  output logic                result
);
  import bedw_pkg::*;

  column_t   win_r [MAX_WIN];
  win_mask_t mask_r;
  column_t   col_and;
  column_t   col_any;
  logic      all_and;
  logic      any_or;

  // column 0 is the newest; row bit 0 is the newest row
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= col_in;
      for (int j = 1; j < MAX_WIN; j++) begin
        win_r[j] <= win_r[j-1];
      end
      mask_r <= mask_in;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_WIN; j++) begin
      col_and[j] = &(win_r[j] | ~mask_r.row_win);
      col_any[j] = |(win_r[j] & mask_r.row_sel);
    end
    all_and = &(col_and | ~mask_r.col_win);
    any_or  = |(col_any & mask_r.col_sel);
    result  = (mode == MODE_DILATE) ? any_or : (mask_r.all_ok && all_and);
  end

endmodule

// File: hw/rtl/binary_erode_dilate_window.sv
// Top level of the streaming binary erode/dilate window.
// Depends on bedw_pkg, bedw_ram, bedw_window and binary_erode_dilate_window_macros.svh.
`include "binary_erode_dilate_window_macros.svh"

// Takes one item per clock unless the output stalls, pixels or flush ticks,
// and gives at most one result pixel per item. Results trail the input by
// ((win_height-1)/2)*img_width + (win_width-1)/2 items, so flush ticks
// after the last pixel drain the frame; frame_end marks its last result.
// An item passes stages s1 and s2 to the output register. The line store
// is one 1024 x 14 RAM holding, per column, the 14 rows above the current
// one; each item reads and writes its column once, which sets the rate at
// one item per clock unless the output stalls, with a bypass for a column
// written on the cycle before. Rows above the frame are masked; the store
// needs no clearing after reset. A known cfg_index write restarts the frame.
module binary_erode_dilate_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic                            in_pixel_on,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_pixel_out,
  output logic                            out_frame_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bedw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bedw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bedw_pkg::*;

  localparam int RST_HALF = (RST_WIN - 1) / 2;
  localparam logic [LAG_W-1:0] LAG_RESET = LAG_W'(RST_HALF * RST_IMG_W + RST_HALF);

  // configuration
  logic                   mode_r, mode_nxt;
  logic [WSIZE_W-1:0]     win_width_r, win_width_nxt;
  logic [WSIZE_W-1:0]     win_height_r, win_height_nxt;
  logic [DIM_FIELD_W-1:0] img_width_r, img_width_nxt;
  logic [DIM_FIELD_W-1:0] img_height_r, img_height_nxt;
  logic [LAG_W-1:0]       lag_r, lag_nxt;
  logic                   cfg_fire;
  logic                   cfg_hit;

  logic [WDIM_W-1:0] w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic [HW_W-1:0]   hw;
  logic [HW_W-1:0]   hh;

  // positions
  logic [INROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic [LAG_W-1:0]   fill_r, fill_nxt;

  logic adv;
  logic in_fire;
  logic done;
  logic tick;
  logic pix0;
  logic emit;
  logic col_last;
  logic out_col_last;
  logic out_row_last;
  logic frame_last;

  logic [ROW_W:0]    row_top;
  logic [WDIM_W:0]   col_top;
  win_mask_t         mask_s0;

  // pipeline
  logic             s1_v_r;
  logic             s1_pix_r;
  logic [COL_W-1:0] s1_addr_r;
  logic             s1_emit_r;
  logic             s1_fe_r;
  win_mask_t        s1_mask_r;
  logic             s2_v_r;
  logic             s2_emit_r;
  logic             s2_fe_r;

  logic               fwd_v_r;
  logic [COL_W-1:0]   fwd_addr_r;
  logic [STORE_W-1:0] fwd_data_r;
  logic [STORE_W-1:0] store_rdata;
  logic [STORE_W-1:0] store_old;
  logic               store_we;
  column_t            col_vec;
  logic               win_result;
  logic               out_load;

  logic out_valid_r;
  logic out_pix_r;
  logic out_fe_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    mode_nxt       = mode_r;
    win_width_nxt  = win_width_r;
    win_height_nxt = win_height_r;
    img_width_nxt  = img_width_r;
    img_height_nxt = img_height_r;
    cfg_hit        = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_index)
        CFG_MODE: begin
          mode_nxt = cfg_data[0];
          cfg_hit  = 1'b1;
        end
        CFG_WIN_WIDTH: begin
          win_width_nxt = cfg_data[WSIZE_W-1:0];
          cfg_hit       = 1'b1;
        end
        CFG_WIN_HEIGHT: begin
          win_height_nxt = cfg_data[WSIZE_W-1:0];
          cfg_hit        = 1'b1;
        end
        CFG_IMG_WIDTH: begin
          img_width_nxt = cfg_data[DIM_FIELD_W-1:0];
          cfg_hit       = 1'b1;
        end
        CFG_IMG_HEIGHT: begin
          img_height_nxt = cfg_data[DIM_FIELD_W-1:0];
          cfg_hit        = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    lag_nxt = LAG_W'(half_size(win_height_nxt)) * LAG_W'(eff_width(img_width_nxt))
            + LAG_W'(half_size(win_width_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_ERODE;
      win_width_r  <= WSIZE_W'(RST_WIN);
      win_height_r <= WSIZE_W'(RST_WIN);
      img_width_r  <= DIM_FIELD_W'(RST_IMG_W);
      img_height_r <= DIM_FIELD_W'(RST_IMG_H);
      lag_r        <= LAG_RESET;
    end else begin
      mode_r       <= mode_nxt;
      win_width_r  <= win_width_nxt;
      win_height_r <= win_height_nxt;
      img_width_r  <= img_width_nxt;
      img_height_r <= img_height_nxt;
      lag_r        <= lag_nxt;
    end
  end

  assign w_eff = eff_width(img_width_r);
  assign h_eff = eff_height(img_height_r);
  assign hw    = half_size(win_width_r);
  assign hh    = half_size(win_height_r);

  // input side control
  assign adv      = !(s2_v_r && s2_emit_r && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign in_fire  = in_valid && in_ready;
  assign done     = in_row_r >= INROW_W'(h_eff);
  assign tick     = in_fire && (done || in_kind == KIND_PIXEL);
  assign pix0     = in_pixel_on && !done;
  assign emit     = tick && (fill_r == lag_r);

  assign col_last     = WDIM_W'(in_col_r) == w_eff - 1'b1;
  assign out_col_last = WDIM_W'(out_col_r) >= w_eff - 1'b1;
  assign out_row_last = HDIM_W'(out_row_r) >= h_eff - 1'b1;
  assign frame_last   = out_row_last && out_col_last;

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    fill_nxt    = fill_r;
    priority if (cfg_hit || (emit && frame_last)) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      fill_nxt    = '0;
    end else if (tick) begin
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      fill_r    <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // window masks for the output position: in-window and in-image
  always_comb begin
    row_top = (ROW_W+1)'(out_row_r) + (ROW_W+1)'(hh);
    col_top = (WDIM_W+1)'(out_col_r) + (WDIM_W+1)'(hw);
    for (int k = 0; k < MAX_WIN; k++) begin
      mask_s0.row_win[k] = SPAN_W'(k) <= {hh, 1'b0};
      mask_s0.row_sel[k] = mask_s0.row_win[k] && ((ROW_W+1)'(k) <= row_top);
      mask_s0.col_win[k] = SPAN_W'(k) <= {hw, 1'b0};
      mask_s0.col_sel[k] = mask_s0.col_win[k] && ((WDIM_W+1)'(k) <= col_top)
                        && (col_top < (WDIM_W+1)'(w_eff) + (WDIM_W+1)'(k));
    end
    mask_s0.all_ok = (mask_s0.row_sel == mask_s0.row_win)
                  && (mask_s0.col_sel == mask_s0.col_win);
  end

  // line store: read at transfer, modify and write back from the s1 stage
  bedw_ram #(
    .WIDTH(STORE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (s1_addr_r),
    .wr_data (col_vec[STORE_W-1:0]),
    .rd_en   (tick),
    .rd_addr (in_col_r),
    .rd_data (store_rdata)
  );

  assign store_we  = s1_v_r && adv;
  assign store_old = (fwd_v_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : store_rdata;
  assign col_vec   = {store_old, s1_pix_r};

  bedw_window u_window (
    .clk      (clk),
    .shift_en (store_we),
    .col_in   (col_vec),
    .mask_in  (s1_mask_r),
    .mode     (mode_r),
    .result   (win_result)
  );

  assign out_load = adv && s2_v_r && s2_emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_r <= tick;
        s2_v_r <= s1_v_r;
      end
      if (store_we) begin
        fwd_v_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r  <= pix0;
      s1_addr_r <= in_col_r;
      s1_emit_r <= emit;
      s1_fe_r   <= emit && frame_last;
      s1_mask_r <= mask_s0;
      s2_emit_r <= s1_emit_r;
      s2_fe_r   <= s1_fe_r;
    end
    if (store_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= col_vec[STORE_W-1:0];
    end
    if (out_load) begin
      out_pix_r <= win_result;
      out_fe_r  <= s2_fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_frame_end = out_fe_r;

  `BEDW_CHECK(a_fill_le_lag, fill_r <= lag_r, "fill count ran past the lag")
  `BEDW_CHECK(a_pos_in_image, (WDIM_W'(in_col_r) < w_eff) && (WDIM_W'(out_col_r) < w_eff) && (HDIM_W'(out_row_r) < h_eff), "position outside the image")
  `BEDW_NEXT(a_frame_restart, emit && frame_last, (in_row_r == '0) && (in_col_r == '0) && (fill_r == '0), "frame did not restart after its last result")
  `BEDW_NEXT(a_result_kept, out_valid_r && !out_ready && !cfg_hit, out_valid_r && $stable(out_pix_r) && $stable(out_fe_r), "pending result lost")

endmodule

// File: bench/tb_binary_erode_dilate_window.sv
// Self-checking testbench for binary_erode_dilate_window: streams binary frames and
// flush ticks, predicts each result pixel with its own window model and checks them.
// Depends on bedw_pkg and the binary_erode_dilate_window RTL.
module tb_binary_erode_dilate_window;
  import bedw_pkg::*;

  localparam int ROWS_KEPT        = MAX_WIN + 1;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int SETTLE_CYCLES    = 8;

  typedef struct packed {
    logic pixel_out;
    logic frame_end;
  } px_result_t;

  class morph_scoreboard;
    bit                     pixel_rows [ROWS_KEPT][MAX_WIDTH];
    logic                   mode;
    logic [WSIZE_W-1:0]     win_w, win_h;
    logic [DIM_FIELD_W-1:0] img_w, img_h;
    int                     in_row, in_col, out_row, out_col;
    px_result_t             expected_q[$];
    int                     errors, n_inputs, n_results, n_frames, n_writes;

    function new();
      mode = MODE_ERODE;
      win_w = WSIZE_W'(RST_WIN);
      win_h = WSIZE_W'(RST_WIN);
      img_w = DIM_FIELD_W'(RST_IMG_W);
      img_h = DIM_FIELD_W'(RST_IMG_H);
      restart();
      errors = 0;
      n_inputs = 0;
      n_results = 0;
      n_frames = 0;
      n_writes = 0;
    endfunction

    function void restart();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int half_of(logic [WSIZE_W-1:0] size);
      int h;
      if (size == '0) return 0;
      h = ((int'(size) - 1) | 1) / 2;
      return (h > HALF_WIN) ? HALF_WIN : h;
    endfunction

    function int frame_w();
      if (img_w == '0) return 1;
      if (int'(img_w) > MAX_WIDTH) return MAX_WIDTH;
      return int'(img_w);
    endfunction

    function int frame_h();
      if (img_h == '0) return 1;
      if (int'(img_h) > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(img_h);
    endfunction

    function int lag();
      return half_of(win_h) * frame_w() + half_of(win_w);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic window_result(int r, int c);
      int  hw, hh, w, h, rr, cc;
      bit  all_on, any_on, p;
      hw = half_of(win_w);
      hh = half_of(win_h);
      w = frame_w();
      h = frame_h();
      all_on = 1'b1;
      any_on = 1'b0;
      for (int dr = -hh; dr <= hh; dr++) begin
        for (int dc = -hw; dc <= hw; dc++) begin
          rr = r + dr;
          cc = c + dc;
          p = 1'b0;
          if (rr >= 0 && rr < h && cc >= 0 && cc < w) p = pixel_rows[rr % ROWS_KEPT][cc];
          if (p) any_on = 1'b1;
          else all_on = 1'b0;
        end
      end
      return (mode == MODE_DILATE) ? any_on : all_on;
    endfunction

    function void note_input(logic k, logic pix);
      int         w, h;
      px_result_t res;
      w = frame_w();
      h = frame_h();
      n_inputs++;
      if (in_row < h) begin
        if (k == KIND_PIXEL) pixel_rows[in_row % ROWS_KEPT][in_col] = pix;
        else return;
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (in_row * w + in_col <= lag()) return;
      res.pixel_out = window_result(out_row, out_col);
      res.frame_end = 1'b0;
      if (out_row >= h - 1 && out_col >= w - 1) begin
        res.frame_end = 1'b1;
        restart();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic pix, logic fend);
      px_result_t want;
      n_results++;
      if (fend === 1'b1) n_frames++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: pixel_out %0d frame_end %0d", pix, fend);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (pix !== want.pixel_out) begin
        $error("pixel_out expected %0d actual %0d", want.pixel_out, pix);
        errors++;
      end
      if (fend !== want.frame_end) begin
        $error("frame_end expected %0d actual %0d", want.frame_end, fend);
        errors++;
      end
    endfunction

    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      case (idx)
        CFG_MODE:       mode = data[0];
        CFG_WIN_WIDTH:  win_w = data[WSIZE_W-1:0];
        CFG_WIN_HEIGHT: win_h = data[WSIZE_W-1:0];
        CFG_IMG_WIDTH:  img_w = data[DIM_FIELD_W-1:0];
        CFG_IMG_HEIGHT: img_h = data[DIM_FIELD_W-1:0];
        default:        return;
      endcase
      restart();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_PIXEL;
  logic                  in_pixel_on = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_pixel_out;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  morph_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_asks = 0;
  int              holds_taken = 0;
  int              hold_left = 0;
  int              sent = 0;
  int              cycle_count = 0;

  binary_erode_dilate_window uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_pixel_on   (in_pixel_on),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_pixel_out, out_frame_end);
      if (hold_asks != holds_taken) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_item(input logic k, input logic p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_pixel_on <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(k, p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_write(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_settings();
    if ($urandom_range(9) < 7) write_reg(CFG_MODE, CFG_DATA_W'($urandom));
    if ($urandom_range(9) < 7) write_reg(CFG_WIN_WIDTH, CFG_DATA_W'($urandom));
    if ($urandom_range(9) < 7) write_reg(CFG_WIN_HEIGHT, CFG_DATA_W'($urandom));
    write_reg(CFG_IMG_WIDTH, ($urandom_range(99) < 8) ? '0 : CFG_DATA_W'($urandom_range(1, 12)));
    write_reg(CFG_IMG_HEIGHT, ($urandom_range(99) < 8) ? '0 : CFG_DATA_W'($urandom_range(1, 10)));
    if ($urandom_range(9) == 0)
      write_reg(CFG_IMG_HEIGHT + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
  endtask

  // full frame: pixels with stray flushes, then the draining ticks; cut short: some pixels, no drain
  task automatic run_frame(input int density, input bit cut_short, input int pause_at);
    int pixels, lag_items;
    pixels = sb.frame_w() * sb.frame_h();
    lag_items = sb.lag();
    if (cut_short) pixels = $urandom_range(pixels - 1);
    for (int i = 0; i < pixels; i++) begin
      if (i == pause_at) wait_drained();
      if ($urandom_range(99) < 4) push_item(KIND_FLUSH, 1'($urandom));
      push_item(KIND_PIXEL, $urandom_range(99) < density);
      sent++;
    end
    if (!cut_short) begin
      for (int i = 0; i < lag_items; i++) begin
        if ($urandom_range(99) < 10) push_item(KIND_PIXEL, 1'($urandom));
        else push_item(KIND_FLUSH, 1'($urandom));
        sent++;
      end
      if ($urandom_range(99) < 15) push_item(KIND_FLUSH, 1'($urandom));
    end
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] ww, input logic [CFG_DATA_W-1:0] wh,
                           input logic [CFG_DATA_W-1:0] iw, input logic [CFG_DATA_W-1:0] ih);
    settle();
    write_reg(CFG_WIN_WIDTH, ww);
    write_reg(CFG_WIN_HEIGHT, wh);
    write_reg(CFG_IMG_WIDTH, iw);
    write_reg(CFG_IMG_HEIGHT, ih);
  endtask

  initial begin
    int goal;
    int frame_no;
    int density;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: start of a 640x480 frame, no results yet
    push_item(KIND_PIXEL, 1'b1);
    push_item(KIND_PIXEL, 1'b0);
    push_item(KIND_PIXEL, 1'b1);

    // 1x1 erode on 2x2: identity, flush inside the frame and after its end ignored
    settle();
    write_reg(CFG_MODE, MODE_ERODE);
    set_frame(1, 1, 2, 2);
    push_item(KIND_PIXEL, 1'b1);
    push_item(KIND_PIXEL, 1'b0);
    push_item(KIND_FLUSH, 1'b1);
    push_item(KIND_PIXEL, 1'b1);
    push_item(KIND_PIXEL, 1'b1);
    push_item(KIND_FLUSH, 1'b0);

    // 3x3 dilate on 3x2, a pixel among the drain ticks acts as a flush
    settle();
    write_reg(CFG_MODE, MODE_DILATE);
    set_frame(3, 3, 3, 2);
    push_item(KIND_PIXEL, 1'b0);
    push_item(KIND_PIXEL, 1'b1);
    push_item(KIND_FLUSH, 1'b0);
    push_item(KIND_PIXEL, 1'b0);
    push_item(KIND_PIXEL, 1'b0);
    push_item(KIND_PIXEL, 1'b0);
    push_item(KIND_PIXEL, 1'b1);
    push_item(KIND_PIXEL, 1'b1);
    push_item(KIND_FLUSH, 1'b1);
    push_item(KIND_FLUSH, 1'b0);
    push_item(KIND_FLUSH, 1'b1);

    // partial frame cut off by the next register write
    settle();
    write_reg(CFG_MODE, MODE_ERODE);
    set_frame(3, 1, 4, 3);
    for (int i = 0; i < 6; i++) push_item(KIND_PIXEL, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 65; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 65; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 0) begin
        set_frame(15, 1, 2047, 1);
        write_reg(CFG_MODE, MODE_DILATE);
        hold_asks++;
        run_frame(50, 1'b0, -1);
        set_frame(15, 3, 1024, 2);
        write_reg(CFG_MODE, MODE_ERODE);
        run_frame(90, 1'b0, -1);
        set_frame(15, 15, 1, 2047);
        run_frame(70, 1'b0, -1);
      end
      goal = sent + RANDOM_PER_PHASE;
      frame_no = 0;
      while (sent < goal) begin
        settle();
        pick_settings();
        if (ph == 2 && frame_no == 1) hold_asks++;
        case ($urandom_range(3))
          0: density = 10;
          1: density = 50;
          2: density = 90;
          default: density = 100;
        endcase
        run_frame(density, $urandom_range(9) == 0,
                  (ph == 1 && frame_no % 5 == 1) ? sb.frame_w() * sb.frame_h() / 2 : -1);
        frame_no++;
      end
    end
    settle();

    $display("Covered %0d input and %0d result transfers over %0d frames, %0d register writes.",
             sb.n_inputs, sb.n_results, sb.n_frames, sb.n_writes);
    $display("Erode and dilate, all window codes, images up to 1024 wide or tall, four idle mixes.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bedw_pkg.sv
hw/rtl/bedw_ram.sv
hw/rtl/bedw_window.sv
hw/rtl/binary_erode_dilate_window.sv
bench/tb_binary_erode_dilate_window.sv
